/* design/sacs_pkg.sv */
package sacs_pkg;

    localparam int SACS_AMOUNT_W   = 30;
    localparam int SACS_DIGITS     = 10;
    localparam int SACS_STEP_BITS  = 3;
    localparam int SACS_STEPS      = SACS_AMOUNT_W / SACS_STEP_BITS;
    localparam int SACS_CNT_W      = $clog2(SACS_STEPS + 1);
    localparam int SACS_BCD_W      = 4 * SACS_DIGITS;
    localparam int SACS_CLIP_W     = 5;
    localparam int SACS_GROUP_SLOTS = 7;
    localparam int SACS_SLOTS      = 1 + 3 * SACS_GROUP_SLOTS;
    localparam int SACS_QUEUE_DEPTH = 2;
    localparam int SACS_CFG_IDX_W  = 3;

    localparam logic [SACS_CLIP_W-1:0] CLIP_INTRO         = 5'd0;
    localparam logic [SACS_CLIP_W-1:0] CLIP_ONE           = 5'd1;
    localparam logic [SACS_CLIP_W-1:0] CLIP_FIVE          = 5'd5;
    localparam logic [SACS_CLIP_W-1:0] CLIP_TEN           = 5'd10;
    localparam logic [SACS_CLIP_W-1:0] CLIP_TENS          = 5'd11;
    localparam logic [SACS_CLIP_W-1:0] CLIP_HUNDRED       = 5'd12;
    localparam logic [SACS_CLIP_W-1:0] CLIP_THOUSAND_DONG = 5'd13;
    localparam logic [SACS_CLIP_W-1:0] CLIP_LAM           = 5'd14;
    localparam logic [SACS_CLIP_W-1:0] CLIP_MOT2          = 5'd15;
    localparam logic [SACS_CLIP_W-1:0] CLIP_LE            = 5'd16;
    localparam logic [SACS_CLIP_W-1:0] CLIP_THOUSAND      = 5'd17;
    localparam logic [SACS_CLIP_W-1:0] CLIP_MILLION       = 5'd18;

    typedef enum logic [SACS_CFG_IDX_W-1:0] {
        CFG_LE    = 3'd0,
        CFG_LAM   = 3'd1,
        CFG_MOT2  = 3'd2,
        CFG_NGHIN = 3'd3,
        CFG_TRIEU = 3'd4
    } cfg_idx_t;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic le;
        logic lam;
        logic mot2;
        logic nghin;
        logic trieu;
    } cfg_t;

    typedef struct packed {
        digit_t [SACS_DIGITS-1:0] dig;
    } plan_t;

endpackage

/* design/sacs_front.sv */
module sacs_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sacs_pkg::SACS_AMOUNT_W-1:0]   amount,
    output logic                                 push,
    input  logic                                 full,
    output sacs_pkg::plan_t                      plan
);
    import sacs_pkg::*;

    localparam int SH_W = SACS_BCD_W + SACS_AMOUNT_W;

    logic                     busy_reg, busy_next;
    logic [SACS_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [SACS_AMOUNT_W-1:0] bin_reg, bin_next;
    logic [SACS_BCD_W-1:0]    bcd_reg, bcd_next;
    logic [SH_W-1:0]          sh;
    logic                     accept;
    logic                     stepping;

    assign in_stall = busy_reg;
    assign accept   = in_valid && !busy_reg;
    assign stepping = busy_reg && (cnt_reg != SACS_CNT_W'(SACS_STEPS));
    assign push     = busy_reg && (cnt_reg == SACS_CNT_W'(SACS_STEPS));
    assign plan.dig = bcd_reg;

    // shift-add-3 conversion, several bits per cycle
    always_comb
    begin
        sh = {bcd_reg, bin_reg};
        for (int b = 0; b < SACS_STEP_BITS; b++)
        begin
            for (int d = 0; d < SACS_DIGITS; d++)
            begin
                if (sh[SACS_AMOUNT_W + 4*d +: 4] >= 4'd5)
                    sh[SACS_AMOUNT_W + 4*d +: 4] = sh[SACS_AMOUNT_W + 4*d +: 4] + 4'd3;
            end
            sh = sh << 1;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = amount;
            bcd_next  = '0;
        end
        else if (stepping)
        begin
            cnt_next = cnt_reg + 1'b1;
            bin_next = sh[SACS_AMOUNT_W-1:0];
            bcd_next = sh[SH_W-1:SACS_AMOUNT_W];
        end
        else if (push && !full)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && (cnt_reg == '0))
        else $error("front did not start conversion");

    a_push_frees: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> !busy_reg)
        else $error("front stayed busy after handing off");

endmodule

/* design/sacs_queue.sv */
module sacs_queue #(
    parameter int unsigned DEPTH = sacs_pkg::SACS_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  sacs_pkg::plan_t  push_data,
    output logic             head_valid,
    input  logic             pop,
    output sacs_pkg::plan_t  head
);
    import sacs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    plan_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count overflow");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue lost a word");

endmodule

/* design/sacs_back.sv */
module sacs_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  sacs_pkg::cfg_t                      cfg,
    input  logic                                head_valid,
    input  sacs_pkg::plan_t                     head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sacs_pkg::SACS_CLIP_W-1:0]    clip_id,
    output logic                                last_clip
);
    import sacs_pkg::*;

    typedef logic [SACS_CLIP_W-1:0] clip_t;

    typedef struct packed {
        logic [SACS_SLOTS-1:0]             mask;
        logic [SACS_SLOTS-1:0][SACS_CLIP_W-1:0] ids;
    } slots_t;

    function automatic clip_t unit_clip(digit_t t, digit_t u, cfg_t c);
        clip_t id;
        id = {1'b0, u};
        if (t != 4'd0 && u == 4'd5 && c.lam)
            id = CLIP_LAM;
        else if (t >= 4'd2 && u == 4'd1 && c.mot2)
            id = CLIP_MOT2;
        return id;
    endfunction

    function automatic slots_t build_slots(plan_t p, cfg_t c);
        slots_t s;
        digit_t h;
        digit_t t;
        digit_t u;
        logic   nz;
        logic   sp;
        logic   sfx;
        clip_t  sfx_id;
        int     base;
        logic   uni_nz;
        logic   mil_nz;
        s.mask    = '0;
        s.ids     = '0;
        s.mask[0] = 1'b1;
        s.ids[0]  = CLIP_INTRO;
        uni_nz = (p.dig[2] != 4'd0) || (p.dig[1] != 4'd0) || (p.dig[0] != 4'd0);
        mil_nz = (p.dig[9] != 4'd0) || (p.dig[8] != 4'd0) || (p.dig[7] != 4'd0)
              || (p.dig[6] != 4'd0);
        for (int g = 0; g < 3; g++)
        begin
            h    = p.dig[8 - 3*g];
            t    = p.dig[7 - 3*g];
            u    = p.dig[6 - 3*g];
            nz   = (h != 4'd0) || (t != 4'd0) || (u != 4'd0);
            base = 1 + SACS_GROUP_SLOTS * g;
            sp   = nz;
            sfx  = 1'b0;
            sfx_id = CLIP_THOUSAND_DONG;
            if (g == 0)
            begin
                sp     = nz && (p.dig[9] == 4'd0);
                sfx    = mil_nz && c.trieu;
                sfx_id = CLIP_MILLION;
            end
            else if (g == 1)
            begin
                sfx    = nz;
                sfx_id = (uni_nz && c.nghin) ? CLIP_THOUSAND : CLIP_THOUSAND_DONG;
            end
            s.mask[base]     = sp && (h != 4'd0);
            s.ids[base]      = {1'b0, h};
            s.mask[base + 1] = sp && (h != 4'd0);
            s.ids[base + 1]  = CLIP_HUNDRED;
            s.mask[base + 2] = sp && (h != 4'd0) && (t == 4'd0) && (u != 4'd0) && c.le;
            s.ids[base + 2]  = CLIP_LE;
            s.mask[base + 3] = sp && (t != 4'd0);
            s.ids[base + 3]  = (t == 4'd1) ? CLIP_TEN : {1'b0, t};
            s.mask[base + 4] = sp && (t >= 4'd2);
            s.ids[base + 4]  = CLIP_TENS;
            s.mask[base + 5] = sp && (u != 4'd0);
            s.ids[base + 5]  = unit_clip(t, u, c);
            s.mask[base + 6] = sfx;
            s.ids[base + 6]  = sfx_id;
        end
        return s;
    endfunction

    plan_t                 plan_reg, plan_next;
    logic [SACS_SLOTS-1:0] pending_reg, pending_next;
    logic                  out_valid_reg, out_valid_next;
    clip_t                 clip_id_reg, clip_id_next;
    logic                  last_clip_reg, last_clip_next;
    slots_t                cur;
    slots_t                nxt;
    logic [SACS_SLOTS-1:0] sel;
    logic [SACS_SLOTS-1:0] rest;
    clip_t                 sel_id;
    logic                  can_emit;
    logic                  emit;
    logic                  is_last;

    assign cur       = build_slots(plan_reg, cfg);
    assign nxt       = build_slots(head, cfg);
    assign sel       = pending_reg & (~pending_reg + 1'b1);
    assign rest      = pending_reg & ~sel;
    assign is_last   = (rest == '0);
    assign can_emit  = !out_valid_reg || !out_stall;
    assign emit      = (pending_reg != '0) && can_emit;
    assign pop       = head_valid && ((pending_reg == '0) || (emit && is_last));
    assign out_valid = out_valid_reg;
    assign clip_id   = clip_id_reg;
    assign last_clip = last_clip_reg;

    always_comb
    begin
        sel_id = '0;
        for (int i = 0; i < SACS_SLOTS; i++)
        begin
            if (sel[i])
                sel_id = sel_id | cur.ids[i];
        end
    end

    always_comb
    begin
        plan_next      = plan_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        clip_id_next   = clip_id_reg;
        last_clip_next = last_clip_reg;
        if (pop)
        begin
            plan_next    = head;
            pending_next = nxt.mask;
        end
        else if (emit)
        begin
            pending_next = rest;
        end
        if (can_emit)
        begin
            out_valid_next = emit;
            if (emit)
            begin
                clip_id_next   = sel_id;
                last_clip_next = is_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg      <= plan_next;
        clip_id_reg   <= clip_id_next;
        last_clip_reg <= last_clip_next;
    end

    a_load_intro: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> pending_reg[0])
        else $error("loaded word lacks intro clip");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != '0) && !can_emit |=> $stable(pending_reg))
        else $error("clip dropped while output stalled");

endmodule

/* design/spoken_amount_clip_sequencer.sv */
// spoken amount clip sequencer
// input channel: in_valid / in_stall carry one amount word (30 bits, whole
// currency units); the word is taken when in_valid is high and in_stall low
// output channel: out_valid / out_stall carry one clip word per cycle when
// not stalled: clip_id plus last_clip, marking the final clip of an amount
// config port: cfg_valid / cfg_ready with cfg_index and cfg_data, one flag
// per index (le, lam, mot2, nghin, trieu); cfg_ready is always high, and
// flags are meant to change only while the block is idle
// every amount yields 1 to 18 clips, always opening with the intro clip
// an amount goes through converter, queue and output register to its clips
// throughput: one clip per cycle unless stalled; each amount takes the
// longer of its clip run and its pass through the 3-bit-per-cycle binary to
// decimal converter; a two-entry queue lets it run ahead of the sequencer
// reset: all flags clear, the queue and output register empty
// output stall: the clip word holds and the sequencer waits; the converter
// and queue keep taking amounts until the queue fills
module spoken_amount_clip_sequencer #(
    parameter int unsigned QUEUE_DEPTH = sacs_pkg::SACS_QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [sacs_pkg::SACS_AMOUNT_W-1:0]   amount,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [sacs_pkg::SACS_CLIP_W-1:0]     clip_id,
    output logic                                 last_clip,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sacs_pkg::SACS_CFG_IDX_W-1:0]  cfg_index,
    input  logic                                 cfg_data
);
    import sacs_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    plan_t front_plan;
    plan_t head;
    logic  push;
    logic  full;
    logic  head_valid;
    logic  pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_LE:    cfg_next.le    = cfg_data;
                CFG_LAM:   cfg_next.lam   = cfg_data;
                CFG_MOT2:  cfg_next.mot2  = cfg_data;
                CFG_NGHIN: cfg_next.nghin = cfg_data;
                CFG_TRIEU: cfg_next.trieu = cfg_data;
                default:   cfg_next       = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    sacs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .amount   (amount),
        .push     (push),
        .full     (full),
        .plan     (front_plan)
    );

    sacs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .push_data  (front_plan),
        .head_valid (head_valid),
        .pop        (pop),
        .head       (head)
    );

    sacs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .clip_id    (clip_id),
        .last_clip  (last_clip)
    );

endmodule
